/* src/sdaf_pkg.sv */
`default_nettype none

package sdaf_pkg;

  // Default number of decimal digits held for the magnitude
  localparam int DigitsDefault = 10;

  // Character codes
  localparam logic [5:0] AsciiZero  = 6'h30;
  localparam logic [5:0] AsciiPoint = 6'h2E;
  localparam logic [5:0] AsciiMinus = 6'h2D;

  // Width of the binary magnitude fed to the converter
  localparam int MagWidth = 32;

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         decimals;
  } item_t;

  typedef struct packed {
    logic [5:0] glyph;
    logic [3:0] offset;
    logic       last;
  } result_t;

  // Bits for a decimal count 0..digits
  function automatic int des_width(input int digits);
    return $clog2(digits + 1);
  endfunction

  // Bits for a character position 0..digits+1
  function automatic int pos_width(input int digits);
    return $clog2(digits + 2);
  endfunction

  // Bits of one converted entry: digits, sign, decimals, last position
  function automatic int entry_width(input int digits);
    return 4 * digits + 1 + des_width(digits) + pos_width(digits);
  endfunction

endpackage

`default_nettype wire

/* src/sdaf_front.sv */
`default_nettype none

module sdaf_front #(
  parameter int DIGITS = sdaf_pkg::DigitsDefault
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      push_i,
  output logic                                           full_o,
  input  wire sdaf_pkg::item_t                           item_i,
  output logic                                           q_push_o,
  input  wire logic                                      q_full_i,
  output logic [sdaf_pkg::entry_width(DIGITS)-1:0]       q_data_o
);

  localparam int DesW = sdaf_pkg::des_width(DIGITS);
  localparam int PosW = sdaf_pkg::pos_width(DIGITS);
  localparam int BcdW = 4 * DIGITS;
  localparam int MagW = sdaf_pkg::MagWidth;
  localparam int CntW = $clog2(MagW);

  logic              busy_q, busy_d;
  logic              hold_q, hold_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [MagW-1:0]   bin_q, bin_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic              neg_q, neg_d;
  logic [DesW-1:0]   des_q, des_d;

  logic              accept;
  logic [MagW-1:0]   raw;
  logic [MagW-1:0]   mag;
  logic [DesW-1:0]   des_sat;
  logic [BcdW-1:0]   adj;
  logic [PosW-1:0]   last_pos;

  // Take a new number while idle, or while the finished one leaves
  assign full_o   = busy_q || (hold_q && q_full_i);
  assign accept   = push_i && !full_o;
  assign q_push_o = hold_q;

  assign raw = MagW'(item_i.value);
  assign mag = raw[MagW-1] ? (~raw + MagW'(1)) : raw;

  // Clamp the decimal count to the digits held
  always_comb begin
    if (32'(item_i.decimals) > 32'(DIGITS - 1)) begin
      des_sat = DesW'(DIGITS - 1);
    end else begin
      des_sat = DesW'(item_i.decimals);
    end
  end

  // Add three to every digit of five or more before the shift
  always_comb begin
    logic [3:0] nib;
    nib = '0;
    adj = '0;
    for (int k = 0; k < DIGITS; k++) begin
      nib = bcd_q[4*k +: 4];
      adj[4*k +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
    end
  end

  // Find how many characters the finished number needs
  always_comb begin
    int hi;
    int shown;
    hi    = 0;
    shown = 0;
    for (int k = 0; k < DIGITS; k++) begin
      if (bcd_q[4*k +: 4] != 4'd0) begin
        hi = k + 1;
      end
    end
    shown = (hi > int'(des_q) + 1) ? hi : int'(des_q) + 1;
    last_pos = PosW'(shown - 1 + ((des_q != '0) ? 1 : 0) + (neg_q ? 1 : 0));
  end

  assign q_data_o = {bcd_q, neg_q, des_q, last_pos};

  // Sequence the shift-add conversion
  always_comb begin
    busy_d = busy_q;
    hold_d = hold_q;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    neg_d  = neg_q;
    des_d  = des_q;
    if (hold_q && !q_full_i) begin
      hold_d = 1'b0;
    end
    if (busy_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[MagW-1]};
      bin_d = {bin_q[MagW-2:0], 1'b0};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(MagW - 1)) begin
        busy_d = 1'b0;
        hold_d = 1'b1;
      end
    end
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bin_d  = mag;
      bcd_d  = '0;
      neg_d  = raw[MagW-1];
      des_d  = des_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      hold_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      hold_q <= hold_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
    des_q <= des_d;
  end

endmodule

`default_nettype wire

/* src/sdaf_fifo.sv */
`default_nettype none

module sdaf_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  output logic              full_o,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic              empty_o,
  output logic [W-1:0]      data_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, wptr_d;
  logic         rptr_q, rptr_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         do_push;
  logic         do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // Advance pointers and track the fill level
  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* src/sdaf_back.sv */
`default_nettype none

module sdaf_back #(
  parameter int DIGITS = sdaf_pkg::DigitsDefault
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      q_empty_i,
  output logic                                           q_pop_o,
  input  wire logic [sdaf_pkg::entry_width(DIGITS)-1:0]  q_data_i,
  output logic                                           empty_o,
  input  wire logic                                      pop_i,
  output sdaf_pkg::result_t                              result_o
);

  localparam int DesW = sdaf_pkg::des_width(DIGITS);
  localparam int PosW = sdaf_pkg::pos_width(DIGITS);
  localparam int BcdW = 4 * DIGITS;

  logic              busy_q, busy_d;
  logic [BcdW-1:0]   dig_q, dig_d;
  logic              neg_q, neg_d;
  logic [DesW-1:0]   des_q, des_d;
  logic [PosW-1:0]   last_q, last_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              oval_q, oval_d;
  sdaf_pkg::result_t res_q, res_d;

  logic              adv;
  logic              at_last;
  logic              at_point;

  assign q_pop_o  = !busy_q && !q_empty_i;
  assign adv      = busy_q && (!oval_q || pop_i);
  assign at_last  = (pos_q == last_q);
  assign at_point = (des_q != '0) && (pos_q == PosW'(des_q));
  assign empty_o  = !oval_q;
  assign result_o = res_q;

  // Emit one character per cycle into the output register while it is empty or being popped
  always_comb begin
    busy_d = busy_q;
    dig_d  = dig_q;
    neg_d  = neg_q;
    des_d  = des_q;
    last_d = last_q;
    pos_d  = pos_q;
    res_d  = res_q;
    oval_d = oval_q;
    if (pop_i) begin
      oval_d = 1'b0;
    end
    if (q_pop_o) begin
      busy_d = 1'b1;
      {dig_d, neg_d, des_d, last_d} = q_data_i;
      pos_d  = '0;
    end
    if (adv) begin
      oval_d        = 1'b1;
      res_d.offset  = 4'(pos_q);
      res_d.last    = at_last;
      pos_d         = pos_q + PosW'(1);
      if (neg_q && at_last) begin
        res_d.glyph = sdaf_pkg::AsciiMinus;
      end else if (at_point) begin
        res_d.glyph = sdaf_pkg::AsciiPoint;
      end else begin
        res_d.glyph = sdaf_pkg::AsciiZero + {2'b00, dig_q[3:0]};
        dig_d       = dig_q >> 4;
      end
      if (at_last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      oval_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      busy_q <= busy_d;
      oval_q <= oval_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    neg_q  <= neg_d;
    des_q  <= des_d;
    last_q <= last_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire

/* src/signed_decimal_ascii_formatter_core.sv */
`default_nettype none

// Formats a signed 32-bit number with a given count of decimal places as ASCII
// characters, least significant first, each tagged with its offset leftward from
// the anchor; the leftmost character carries last. Leading zeros above the point
// are blanked, a fraction keeps a leading zero, negative numbers get a minus sign
// (the most negative value shows as -2147483648), and counts of DIGITS or more
// are clamped to DIGITS-1. A front converter runs one shift-add step per bit of
// the magnitude, then hands the number over; it takes no new number until the
// last one is being handed over. A two-entry queue then feeds an emitter that
// sends one character per cycle (up to DIGITS+2 per number) into an output
// register while that register is empty or being popped. No clearing after reset.
module signed_decimal_ascii_formatter_core #(
  parameter int DIGITS = sdaf_pkg::DigitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire sdaf_pkg::item_t   item_i,
  output logic                   empty,
  input  wire logic              pop,
  output sdaf_pkg::result_t      result_o
);

  localparam int EntryW = sdaf_pkg::entry_width(DIGITS);

  logic              f_push;
  logic              f_full;
  logic [EntryW-1:0] f_data;
  logic              b_pop;
  logic              b_empty;
  logic [EntryW-1:0] b_data;

  // Convert and classify
  sdaf_front #(
    .DIGITS (DIGITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .item_i   (item_i),
    .q_push_o (f_push),
    .q_full_i (f_full),
    .q_data_o (f_data)
  );

  // Decouple conversion from emission
  sdaf_fifo #(
    .W (EntryW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .full_o  (f_full),
    .data_i  (f_data),
    .pop_i   (b_pop),
    .empty_o (b_empty),
    .data_o  (b_data)
  );

  // Emit characters
  sdaf_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (b_empty),
    .q_pop_o   (b_pop),
    .q_data_i  (b_data),
    .empty_o   (empty),
    .pop_i     (pop),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire
